FILE: src/ydte_pkg.sv
// ----------------------------------------------------------------------------
// ydte_pkg
// Beat types and constants for the year / day-of-year / time to epoch block.
// ----------------------------------------------------------------------------
`default_nettype none

package ydte_pkg;

	localparam int YearW   = 12;
	localparam int DoyW    = 9;
	localparam int HourW   = 5;
	localparam int MinuteW = 6;
	localparam int SecondW = 6;
	localparam int NsW     = 30;
	localparam int EpochSW = 34;
	localparam int EpochNW = 64;

	localparam int CentW   = 6;
	localparam int DaysW   = 21;
	localparam int HmsW    = 17;
	localparam int TimeW   = 38;
	localparam int SplitW  = 19;

	localparam logic [YearW-1:0] EpochYear     = 12'd1970;
	localparam logic [YearW-1:0] LeapBaseYear  = 12'd1968;
	localparam logic [YearW-1:0] Century       = 12'd100;
	localparam logic [12:0]      Recip100      = 13'd5243;
	localparam int               Recip100Shift = 19;
	localparam logic [DoyW-1:0]  LastDayFebLeap = 9'd60;

	localparam logic [DaysW-1:0] DaysPerYear = 21'd365;
	localparam logic [DaysW-1:0] LeapBias    = 21'd15;
	localparam logic [HmsW-1:0]  SecPerHour  = 17'd3600;
	localparam logic [HmsW-1:0]  SecPerMin   = 17'd60;
	localparam logic [TimeW-1:0] SecPerDay   = 38'd86400;
	localparam logic [NsW-1:0]   NsPerSecond = 30'd1000000000;

	typedef struct packed {
		logic [YearW-1:0]   year;
		logic [DoyW-1:0]    day_of_year;
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic [SecondW-1:0] second;
		logic [NsW-1:0]     nanosecond;
	} ydte_in_t;

	typedef struct packed {
		logic [EpochSW-1:0] epoch_seconds;
		logic [EpochNW-1:0] epoch_nanoseconds;
	} ydte_out_t;

endpackage

`default_nettype wire

FILE: src/year_doy_time_to_epoch.sv
// ----------------------------------------------------------------------------
// year_doy_time_to_epoch: six-stage pipeline.
// Throughput is one beat per cycle; stalls stop only the stages that are full.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module year_doy_time_to_epoch (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire ydte_pkg::ydte_in_t item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output ydte_pkg::ydte_out_t    result
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic [ydte_pkg::YearW-1:0]   ysat;
	logic [24:0]                  prod100;
	logic [ydte_pkg::YearW-1:0]   y_s1;
	logic [ydte_pkg::CentW-1:0]   q_s1;
	logic [ydte_pkg::DoyW-1:0]    doy_s1;
	logic [ydte_pkg::HourW-1:0]   hour_s1;
	logic [ydte_pkg::MinuteW-1:0] min_s1;
	logic [ydte_pkg::SecondW-1:0] sec_s1;
	logic [ydte_pkg::NsW-1:0]     ns_s1;

	logic [ydte_pkg::YearW-1:0]   q100;
	logic                         cent, leap, adj;
	logic [ydte_pkg::YearW-1:0]   yoff_s2, ya_s2;
	logic [ydte_pkg::CentW-1:0]   qa_s2;
	logic [ydte_pkg::DoyW-1:0]    doy_s2;
	logic [ydte_pkg::HourW-1:0]   hour_s2;
	logic [ydte_pkg::MinuteW-1:0] min_s2;
	logic [ydte_pkg::SecondW-1:0] sec_s2;
	logic [ydte_pkg::NsW-1:0]     ns_s2;

	logic [ydte_pkg::YearW-1:0]   yl;
	logic [ydte_pkg::DaysW-1:0]   days;
	logic [ydte_pkg::HmsW-1:0]    hms;
	logic signed [ydte_pkg::DaysW-1:0] days_s3;
	logic [ydte_pkg::HmsW-1:0]    hms_s3;
	logic [ydte_pkg::NsW-1:0]     ns_s3;

	logic signed [ydte_pkg::TimeW-1:0] tsec;
	logic signed [ydte_pkg::TimeW-1:0] t_s4;
	logic [ydte_pkg::NsW-1:0]     ns_s4;

	logic [ydte_pkg::SplitW+ydte_pkg::NsW-1:0]        pl_s5;
	logic signed [ydte_pkg::SplitW+ydte_pkg::NsW:0]   ph_s5;
	logic [ydte_pkg::EpochSW-1:0] sec_s5;
	logic [ydte_pkg::NsW-1:0]     ns_s5;

	logic [ydte_pkg::EpochNW-1:0] nano;
	ydte_pkg::ydte_out_t          res_s6;

	assign rdy_s6 = !v_s6 || !result_stall;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Years before the epoch saturate; the century count uses a reciprocal.
	always_comb begin
		ysat = (item.year < ydte_pkg::EpochYear) ? ydte_pkg::EpochYear : item.year;
		prod100 = 25'(ysat) * 25'(ydte_pkg::Recip100);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			y_s1    <= ysat;
			q_s1    <= prod100[ydte_pkg::Recip100Shift +: ydte_pkg::CentW];
			doy_s1  <= item.day_of_year;
			hour_s1 <= item.hour;
			min_s1  <= item.minute;
			sec_s1  <= item.second;
			ns_s1   <= item.nanosecond;
		end
	end

	// A leap year counts its own leap day only after February 29.
	always_comb begin
		q100 = {6'b0, q_s1} * ydte_pkg::Century;
		cent = (y_s1 == q100);
		leap = (y_s1[1:0] == 2'b00) && (!cent || (q_s1[1:0] == 2'b00));
		adj  = leap && (doy_s1 <= ydte_pkg::LastDayFebLeap);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			yoff_s2 <= y_s1 - ydte_pkg::EpochYear;
			ya_s2   <= y_s1 - {11'b0, adj};
			qa_s2   <= q_s1 - {5'b0, adj && cent};
			doy_s2  <= doy_s1;
			hour_s2 <= hour_s1;
			min_s2  <= min_s1;
			sec_s2  <= sec_s1;
			ns_s2   <= ns_s1;
		end
	end

	// The day count is at least minus one, so it wraps safely in this width.
	always_comb begin
		yl   = (ya_s2 - ydte_pkg::LeapBaseYear) >> 2;
		days = 21'(yoff_s2) * ydte_pkg::DaysPerYear + 21'(yl) - 21'(qa_s2)
			+ 21'(qa_s2 >> 2) + ydte_pkg::LeapBias + 21'(doy_s2) - 21'd1;
		hms  = 17'(hour_s2) * ydte_pkg::SecPerHour + 17'(min_s2) * ydte_pkg::SecPerMin
			+ 17'(sec_s2);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			days_s3 <= $signed(days);
			hms_s3  <= hms;
			ns_s3   <= ns_s2;
		end
	end

	always_comb begin
		tsec = $signed({{(ydte_pkg::TimeW-ydte_pkg::DaysW){days_s3[ydte_pkg::DaysW-1]}},
			days_s3}) * $signed(ydte_pkg::SecPerDay)
			+ $signed({{(ydte_pkg::TimeW-ydte_pkg::HmsW){1'b0}}, hms_s3});
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			t_s4  <= tsec;
			ns_s4 <= ns_s3;
		end
	end

	// The nanosecond product is split into two partial products.
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			pl_s5  <= 49'(t_s4[ydte_pkg::SplitW-1:0]) * 49'(ydte_pkg::NsPerSecond);
			ph_s5  <= 50'($signed(t_s4[ydte_pkg::TimeW-1:ydte_pkg::SplitW]))
				* 50'($signed({1'b0, ydte_pkg::NsPerSecond}));
			sec_s5 <= t_s4[ydte_pkg::EpochSW-1:0];
			ns_s5  <= ns_s4;
		end
	end

	always_comb begin
		nano = ({{(ydte_pkg::EpochNW-50){ph_s5[49]}}, ph_s5} << ydte_pkg::SplitW)
			+ {15'b0, pl_s5} + {34'b0, ns_s5};
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			res_s6.epoch_seconds     <= sec_s5;
			res_s6.epoch_nanoseconds <= nano;
		end
	end

	assign result_valid = v_s6;
	assign result       = res_s6;

`ifndef SYNTHESIS
	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && result_stall) |-> item_stall)
		else $error("full pipeline did not stall the input");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_s4) |=> v_s4)
		else $error("beat lost between stages three and four");

	a_input_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> v_s1)
		else $error("accepted beat did not enter the pipeline");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_year_doy_time_to_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_year_doy_time_to_epoch
// Drives decoded time codes into the epoch converter and checks every result
// beat against a predictor of the Gregorian leap-day count, with random idle
// cycles on both sides and a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------

module tb_year_doy_time_to_epoch;

	localparam longint unsigned BaseYear   = 1970;
	localparam longint unsigned YearDays   = 365;
	localparam longint unsigned FebLeapDay = 60;
	localparam longint unsigned NsPerSec   = 1000000000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	ydte_pkg::ydte_in_t  item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	ydte_pkg::ydte_out_t result;

	ydte_pkg::ydte_in_t  time_codes[$];
	ydte_pkg::ydte_out_t epoch_due[$];
	int        fail_count = 0;
	int        cycle_no = 0;
	wire       calm = (cycle_no >= 150) && (cycle_no < 300);

	year_doy_time_to_epoch u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial forever #2 clk = ~clk;

	function automatic bit leap_year(longint unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// The leap day of the current year is counted only once Feb 29 has passed.
	function automatic ydte_pkg::ydte_out_t to_epoch(ydte_pkg::ydte_in_t tc);
		longint unsigned y;
		longint unsigned ly;
		longint unsigned doy;
		longint unsigned days;
		longint unsigned secs;
		ydte_pkg::ydte_out_t r;
		y = 64'(tc.year);
		if (y < BaseYear) begin
			y = BaseYear;
		end
		doy = 64'(tc.day_of_year);
		ly = y;
		if (leap_year(y) && doy <= FebLeapDay) begin
			ly = y - 1;
		end
		days = (y - BaseYear) * YearDays;
		days = days + (ly - BaseYear + 2) / 4;
		days = days - (ly / 100 - 15);
		days = days + ly / 400;
		days = days + doy - 1;
		secs = days * 24 + 64'(tc.hour);
		secs = secs * 60 + 64'(tc.minute);
		secs = secs * 60 + 64'(tc.second);
		r.epoch_seconds = secs[ydte_pkg::EpochSW-1:0];
		r.epoch_nanoseconds = secs * NsPerSec + 64'(tc.nanosecond);
		return r;
	endfunction

	task automatic add_code(input int unsigned y, input int unsigned d, input int unsigned h,
			input int unsigned m, input int unsigned s, input int unsigned ns);
		ydte_pkg::ydte_in_t tc;
		tc.year = y[ydte_pkg::YearW-1:0];
		tc.day_of_year = d[ydte_pkg::DoyW-1:0];
		tc.hour = h[ydte_pkg::HourW-1:0];
		tc.minute = m[ydte_pkg::MinuteW-1:0];
		tc.second = s[ydte_pkg::SecondW-1:0];
		tc.nanosecond = ns[ydte_pkg::NsW-1:0];
		time_codes.push_back(tc);
	endtask

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				epoch_due.push_back(to_epoch(item));
			end
			if (!item_valid || !item_stall) begin
				if (time_codes.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
					item <= time_codes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_check
		ydte_pkg::ydte_out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (epoch_due.size() == 0) begin
					$display("%0t: result beat with none expected: %h", $realtime, result);
					fail_count++;
				end else begin
					want = epoch_due.pop_front();
					if (result.epoch_seconds !== want.epoch_seconds) begin
						$display("%0t: epoch_seconds expected %0d actual %0d", $realtime,
							want.epoch_seconds, result.epoch_seconds);
						fail_count++;
					end
					if (result.epoch_nanoseconds !== want.epoch_nanoseconds) begin
						$display("%0t: epoch_nanoseconds expected %0d actual %0d", $realtime,
							want.epoch_nanoseconds, result.epoch_nanoseconds);
						fail_count++;
					end
				end
			end
			result_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	initial begin
		int unsigned years[11] = '{1970, 1972, 2000, 2024, 2099, 2100, 2104, 2200, 2300,
			2396, 2399};
		int unsigned days[6] = '{1, 59, 60, 61, 365, 366};
		int unsigned pick;

		add_code(1970, 1, 0, 0, 0, 0);
		add_code(2399, 366, 23, 59, 59, 999999999);
		add_code(1970, 1, 0, 0, 0, 30'h3FFFFFFF);
		add_code(1972, 60, 12, 0, 0, 0);
		add_code(1972, 61, 0, 0, 1, 0);
		add_code(2000, 59, 23, 59, 59, 999999999);
		add_code(2000, 60, 0, 0, 0, 0);
		add_code(2000, 61, 0, 0, 0, 0);
		add_code(2100, 59, 1, 2, 3, 4);
		add_code(2100, 60, 1, 2, 3, 4);
		add_code(2100, 61, 1, 2, 3, 4);
		add_code(2023, 365, 23, 59, 59, 999999999);
		add_code(2024, 366, 23, 59, 59, 500000000);
		add_code(2038, 19, 3, 14, 7, 0);
		add_code(2400, 60, 0, 0, 0, 0);
		add_code(2400, 61, 0, 0, 0, 0);
		add_code(0, 100, 6, 30, 15, 123456789);
		add_code(1969, 1, 0, 0, 0, 0);
		add_code(1970, 0, 0, 0, 0, 0);
		add_code(2600, 1, 0, 0, 0, 0);
		add_code(4095, 511, 31, 63, 63, 30'h3FFFFFFF);
		add_code(2050, 200, 31, 63, 63, 0);

		// Mostly valid codes, a share aimed at leap and year boundaries, and
		// some raw noise over the full width of every field.
		for (int i = 0; i < 400; i++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				add_code($urandom_range(4095), $urandom_range(511), $urandom_range(31),
					$urandom_range(63), $urandom_range(63), $urandom_range(30'h3FFFFFFF));
			end else if (pick < 45) begin
				add_code(years[$urandom_range(10)], days[$urandom_range(5)],
					$urandom_range(23), $urandom_range(59), $urandom_range(59),
					$urandom_range(999999999));
			end else begin
				add_code($urandom_range(2399, 1970), $urandom_range(366, 1),
					$urandom_range(23), $urandom_range(59), $urandom_range(59),
					$urandom_range(999999999));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (time_codes.size() != 0 || item_valid) @(posedge clk);
		while (epoch_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("year_doy_time_to_epoch regression: pass");
		end else begin
			$display("year_doy_time_to_epoch regression: fail");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("year_doy_time_to_epoch regression: fail");
		$finish;
	end

endmodule
